[sv/rdq_pkg.sv]
// ---------------------------------------------------------------------------
// rdq_pkg: shared types and constants for the request deque
// Operation codes, status codes and the entry record used by every cell.
// ---------------------------------------------------------------------------
`default_nettype none
package rdq_pkg;
   localparam int DEPTH_DEFAULT = 16;
   localparam int SERIAL_W      = 31;
   localparam logic [SERIAL_W-1:0] SERIAL_TOP = {SERIAL_W{1'b1}};

   typedef enum logic [2:0] {
      KIND_PUSH_BACK  = 3'd0,
      KIND_PUSH_FRONT = 3'd1,
      KIND_BEGIN      = 3'd2,
      KIND_COMPLETE   = 3'd3,
      KIND_DROP       = 3'd4,
      KIND_CLEAR      = 3'd5,
      KIND_RSVD6      = 3'd6,
      KIND_RSVD7      = 3'd7
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RSVD  = 2'd3
   } status_type;

   typedef struct packed {
      logic [15:0]         handle;
      logic [15:0]         rtype;
      logic [31:0]         cookie;
      logic [15:0]         flags;
      logic [SERIAL_W-1:0] serial;
   } entry_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic      shift_up;   // push front: take left neighbour
      logic      shift_down; // begin: take right neighbour
      logic      write_back; // push back: write if cell index == count
      logic      write_head; // push front: cell 0 takes new entry
      logic      compact;    // drop pass step
   } cell_ctl_type;
endpackage
`default_nettype wire

[sv/rdq_cell.sv]
// ---------------------------------------------------------------------------
// rdq_cell: one queue position
// Holds one entry; loads a new entry or shifts one place per cycle when commanded.
// ---------------------------------------------------------------------------
`default_nettype none
module rdq_cell (
   input  wire logic                 clock,
   input  wire rdq_pkg::cell_ctl_type ctl,
   input  wire logic                 is_tail,     // index == count
   input  wire logic                 in_drop,     // this or a lower cell matched
   input  wire rdq_pkg::entry_type   new_entry,
   input  wire rdq_pkg::entry_type   from_left,   // cell i-1
   input  wire rdq_pkg::entry_type   from_right,  // cell i+1
   output rdq_pkg::entry_type        entry_q
);
   rdq_pkg::entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.write_head) begin
         entry_in = new_entry;
      end else if (ctl.shift_up) begin
         entry_in = from_left;
      end else if (ctl.shift_down) begin
         entry_in = from_right;
      end else if (ctl.write_back && is_tail) begin
         entry_in = new_entry;
      end else if (ctl.compact && in_drop) begin
         entry_in = from_right;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;
endmodule
`default_nettype wire

[sv/request_deque_with_inflight_slot.sv]
// ---------------------------------------------------------------------------
// request_deque_with_inflight_slot: bounded request deque, one in-flight slot
// Queue entries live in a row of cells that shift as a chain; drop by cookie
// removes the first matching entry per cycle, closing the gap as it goes.
// ---------------------------------------------------------------------------
//  channel | dir | tdata (low bit first)                      | tuser
//  req_    | in  | handle16 type16 cookie32 flags16 rc32 = 112 | kind3
//  rsp_    | out | serial31 handle16 type16 cookie32 flags16   | status2
//          |     |   rc32 dropped5 depth5 busy1 = 154 -> 160   |
//
//  Push, begin, complete, clear: result registered at the accepting edge;
//  the next request is accepted only once the result has been taken.
//  Drop: each step of the pass removes the first matching entry; the result
//  is registered once no matching entry is left.
//  req_tready is low while a drop pass runs or a result waits to be taken.
//  Synchronous reset clears count, slot valid and response valid, sets the serial
//  counter to 1 and returns to idle; entry and slot storage are not cleared.
`default_nettype none
module request_deque_with_inflight_slot #(
   parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,  // handle, type, cookie, flags, rc
   input  wire logic [2:0]   req_tuser,  // kind
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [159:0]      rsp_tdata,  // serial,handle,type,cookie,flags,rc,
                                         // dropped,depth,busy, zero pad
   output logic [1:0]        rsp_tuser   // status
);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = rdq_pkg::SERIAL_W;

   typedef enum logic [1:0] {S_IDLE = 2'b01, S_DROP = 2'b10} state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] dropped_ff, dropped_in;
   logic [SW-1:0] serctr_ff, serctr_in;
   logic slot_valid_ff, slot_valid_in;
   rdq_pkg::entry_type slot_ff, slot_in;
   logic [31:0] key_ff;
   logic        rv_ff, rv_in;
   logic [159:0] rd_ff, rd_in;
   logic [1:0]   rs_ff, rs_in;

   rdq_pkg::entry_type cells [DEPTH];
   rdq_pkg::entry_type new_entry;
   rdq_pkg::cell_ctl_type ctl;
   logic [DEPTH-1:0] hit, in_drop;
   logic any_hit;

   logic accept;
   rdq_pkg::kind_type kind;
   logic [15:0] f_handle, f_type, f_flags;
   logic [31:0] f_cookie, f_rc;

   assign kind     = rdq_pkg::kind_type'(req_tuser);
   assign f_handle = req_tdata[15:0];
   assign f_type   = req_tdata[31:16];
   assign f_cookie = req_tdata[63:32];
   assign f_flags  = req_tdata[79:64];
   assign f_rc     = req_tdata[111:80];

   assign req_tready = (state_ff == S_IDLE) && !rv_ff;
   assign accept     = req_tvalid && req_tready;

   // match flags: valid entries equal to key; in_drop is prefix-or
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         hit[i] = (CW'(i) < count_ff) && (cells[i].cookie == key_ff);
      end
      in_drop[0] = hit[0];
      for (int i = 1; i < DEPTH; i++) begin
         in_drop[i] = in_drop[i-1] | hit[i];
      end
      any_hit = in_drop[DEPTH-1];
   end

   logic full, push_ok;
   assign full    = (count_ff == CW'(DEPTH));
   assign push_ok = !full;

   always_comb begin
      new_entry.handle = f_handle;
      new_entry.rtype  = f_type;
      new_entry.cookie = f_cookie;
      new_entry.flags  = (kind == rdq_pkg::KIND_PUSH_BACK) ? 16'd0 : f_flags;
      new_entry.serial = serctr_ff;

      ctl = '0;
      if (accept) begin
         unique case (kind)
            rdq_pkg::KIND_PUSH_BACK:  ctl.write_back = push_ok;
            rdq_pkg::KIND_PUSH_FRONT: begin
               ctl.write_head = push_ok;
               ctl.shift_up   = push_ok;
            end
            rdq_pkg::KIND_BEGIN:
               ctl.shift_down = !slot_valid_ff && (count_ff != '0);
            default: ;
         endcase
      end
      if (state_ff == S_DROP) ctl.compact = any_hit;
   end

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      rdq_pkg::cell_ctl_type cc;
      always_comb begin
         cc = ctl;
         if (g != 0) cc.write_head = 1'b0;
         else        cc.shift_up   = ctl.shift_up && !ctl.write_head;
      end
      rdq_cell u_cell (
         .clock     (clock),
         .ctl       (cc),
         .is_tail   (count_ff == CW'(g)),
         .in_drop   (in_drop[g]),
         .new_entry (new_entry),
         .from_left (cells[(g == 0) ? 0 : g-1]),
         .from_right(cells[(g == DEPTH-1) ? g : g+1]),
         .entry_q   (cells[g])
      );
   end

   function automatic logic [159:0] pack_rsp(
      input logic [SW-1:0] ser, input rdq_pkg::entry_type e, input logic [31:0] rc,
      input logic [4:0] drp, input logic [4:0] dep, input logic busy);
      logic [159:0] r;
      r = '0;
      r[30:0]    = ser;
      r[46:31]   = e.handle;
      r[62:47]   = e.rtype;
      r[94:63]   = e.cookie;
      r[110:95]  = e.flags;
      r[142:111] = rc;
      r[147:143] = drp;
      r[152:148] = dep;
      r[153]     = busy;
      return r;
   endfunction

   rdq_pkg::entry_type zero_e;
   assign zero_e = '0;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dropped_in    = dropped_ff;
      serctr_in     = serctr_ff;
      slot_valid_in = slot_valid_ff;
      slot_in       = slot_ff;
      rv_in = rv_ff && !rsp_tready;
      rd_in = rd_ff;
      rs_in = rs_ff;
      if (accept) begin
         rv_in = 1'b1;
         rs_in = rdq_pkg::ST_OK;
         rd_in = pack_rsp('0, zero_e, '0, '0, 5'(count_ff), slot_valid_ff);
         unique case (kind) inside
            rdq_pkg::KIND_PUSH_BACK, rdq_pkg::KIND_PUSH_FRONT: begin
               if (full) begin
                  rs_in = rdq_pkg::ST_FULL;
               end else begin
                  count_in  = count_ff + 1'b1;
                  serctr_in = (serctr_ff == rdq_pkg::SERIAL_TOP) ? SW'(1)
                              : serctr_ff + 1'b1;
                  rd_in = pack_rsp(serctr_ff, zero_e, '0, '0, 5'(count_in),
                                   slot_valid_ff);
               end
            end
            rdq_pkg::KIND_BEGIN: begin
               if (slot_valid_ff || count_ff == '0) begin
                  rs_in = rdq_pkg::ST_EMPTY;
               end else begin
                  slot_in       = cells[0];
                  slot_valid_in = 1'b1;
                  count_in      = count_ff - 1'b1;
                  rd_in = pack_rsp(cells[0].serial, cells[0], '0, '0,
                                   5'(count_in), 1'b1);
               end
            end
            rdq_pkg::KIND_COMPLETE: begin
               if (!slot_valid_ff) begin
                  rs_in = rdq_pkg::ST_EMPTY;
               end else begin
                  slot_valid_in = 1'b0;
                  rd_in = pack_rsp(slot_ff.serial, slot_ff, f_rc, '0,
                                   5'(count_ff), 1'b0);
               end
            end
            rdq_pkg::KIND_DROP: begin
               rv_in      = 1'b0;
               dropped_in = '0;
               state_in   = S_DROP;
            end
            rdq_pkg::KIND_CLEAR: begin
               count_in      = '0;
               slot_valid_in = 1'b0;
               slot_in       = '0;
               serctr_in     = SW'(1);
               rd_in = pack_rsp('0, zero_e, '0, '0, '0, 1'b0);
            end
            default: ;
         endcase
      end
      if (state_ff == S_DROP) begin
         if (any_hit) begin
            count_in   = count_ff - 1'b1;
            dropped_in = dropped_ff + 1'b1;
         end else begin
            state_in = S_IDLE;
            rv_in    = 1'b1;
            rs_in    = rdq_pkg::ST_OK;
            rd_in    = pack_rsp('0, zero_e, '0, 5'(dropped_ff), 5'(count_ff),
                                slot_valid_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         dropped_ff    <= '0;
         serctr_ff     <= SW'(1);
         slot_valid_ff <= 1'b0;
         rv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         serctr_ff     <= serctr_in;
         slot_valid_ff <= slot_valid_in;
         rv_ff         <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      rd_ff   <= rd_in;
      rs_ff   <= rs_in;
      if (accept) key_ff <= f_cookie;
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rd_ff;
   assign rsp_tuser  = rs_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH)) else $error("count above depth");
   a_serial_nonzero: assert property (@(posedge clock) disable iff (reset)
      serctr_ff != '0) else $error("serial counter zero");
   a_no_accept_in_drop: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DROP |-> !req_tready) else $error("accept during drop");
   a_drop_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DROP && any_hit) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("drop step did not remove entry");
endmodule
`default_nettype wire
